/* rtl/tds_pkg.sv */
// Shared constants, opcodes, sequencer states and control types of the trailed domain store.
package tds_pkg;

    localparam int unsigned ENTRIES   = 64;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned DEPTH_W   = 6;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned MAX_DEPTH = 64;

    typedef enum logic [2:0] {
        OP_APPEND        = 3'd0,
        OP_REMOVE        = 3'd1,
        OP_REDUCE        = 3'd2,
        OP_RESTORE_DEPTH = 3'd3,
        OP_RESTORE_INDEX = 3'd4,
        OP_QUERY         = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_VAL_A,
        S_VAL_B,
        S_VAL_C
    } t_state;

    typedef struct packed {
        logic busy;
        logic accept;
        logic exec;
        logic scan;
        logic val_a;
        logic val_b;
        logic val_c;
    } t_ctrl;

endpackage

/* rtl/tds_ctrl.sv */
// Sequencer of the trailed domain store: steps one word through execute, scan and readout.
module tds_ctrl
    import tds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_scan_last,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_scan_last) begin
                    n_state = S_VAL_A;
                end
            end
            S_VAL_A: begin
                n_state = S_VAL_B;
            end
            S_VAL_B: begin
                n_state = S_VAL_C;
            end
            S_VAL_C: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.busy   = (r_state != S_IDLE);
        o_ctrl.accept = (r_state == S_IDLE) && i_start;
        o_ctrl.exec   = (r_state == S_EXEC);
        o_ctrl.scan   = (r_state == S_SCAN);
        o_ctrl.val_a  = (r_state == S_VAL_A);
        o_ctrl.val_b  = (r_state == S_VAL_B);
        o_ctrl.val_c  = (r_state == S_VAL_C);
    end

endmodule

/* rtl/trailed_domain_store_core.sv */
// One constraint-solver variable domain with a per-entry removal depth trail.
// A word accepted while idle passes through execute, the scan and readout before its result
// is strobed; the scan walks one entry per cycle over the loaded entries, and is still entered
// when none are loaded. busy stays high, and no new word is taken, until the result cycle.
// Reset is synchronous and active low: counts clear and every entry reads as present;
// the value and depth memories are not cleared. The receiver cannot stall the result.
module trailed_domain_store_core
    import tds_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_opcode,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic signed [VALUE_W-1:0] i_new_value,
    output logic                      o_strobe,
    output logic [CNT_W-1:0]          o_removed_total,
    output logic [CNT_W-1:0]          o_entries_loaded,
    output logic [IDX_W-1:0]          o_first_present_index,
    output logic                      o_any_present,
    output logic signed [VALUE_W-1:0] o_single_value,
    output logic                      o_single_left,
    output logic signed [VALUE_W-1:0] o_indexed_value,
    output logic                      o_op_error
);

    // Sequencer control for the current word.
    t_ctrl ctrl;
    logic  scan_last;

    // Captured word.
    t_opcode              r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [DEPTH_W-1:0]   r_depth;
    logic [VALUE_W-1:0]   r_new_value;

    // Domain state. The present flags live in flops so that reset sets them all at once.
    logic [ENTRIES-1:0]   r_present, n_present;
    logic [CNT_W-1:0]     r_loaded, n_loaded;
    logic [CNT_W-1:0]     r_removed, n_removed;

    // Per-word working registers: error, walk-modify enable, scan pointer and summary.
    logic                 r_err, n_err;
    logic                 r_mod, n_mod;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_first, n_first;
    logic [1:0]           r_pcnt, n_pcnt;
    logic [VALUE_W-1:0]   r_single;

    // Memories and their ports. Both have one write and one registered read per cycle.
    logic [VALUE_W-1:0]   value_mem [ENTRIES];
    logic [DEPTH_W-1:0]   depth_mem [ENTRIES];
    logic                 value_we;
    logic [IDX_W-1:0]     value_raddr;
    logic [VALUE_W-1:0]   r_value_rd;
    logic                 depth_we;
    logic [IDX_W-1:0]     depth_waddr;
    logic [IDX_W-1:0]     depth_raddr;
    logic [DEPTH_W-1:0]   r_depth_rd;

    // Scan helpers for the entry under the pointer.
    logic                 scan_hit;
    logic                 scan_cur;
    logic                 scan_new;
    logic                 idx_ok;
    logic                 depth_ok;

    tds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_scan_last (scan_last),
        .o_ctrl      (ctrl)
    );

    assign busy = ctrl.busy;

    // The walk covers entries 0 to loaded-1; an empty domain still passes through the scan.
    assign scan_hit  = ({1'b0, r_ptr} < r_loaded);
    assign scan_last = (r_loaded == '0) || ({1'b0, r_ptr} == (r_loaded - CNT_W'(1)));
    assign scan_cur  = r_present[r_ptr];
    assign idx_ok    = ({1'b0, r_idx} < r_loaded);
    assign depth_ok  = ({1'b0, r_depth} < CNT_W'(MAX_DEPTH));

    // The depth memory is read at the word's index on accept (for restore index),
    // at entry 0 during execute, and one entry ahead of the pointer during the scan.
    always_comb begin
        if (ctrl.scan) begin
            depth_raddr = r_ptr + IDX_W'(1);
        end else if (ctrl.exec) begin
            depth_raddr = '0;
        end else begin
            depth_raddr = i_entry_index;
        end
    end

    // The value memory is read at the first present entry, then at the word's index.
    assign value_raddr = ctrl.val_a ? r_first : r_idx;

    always_comb begin
        n_present   = r_present;
        n_loaded    = r_loaded;
        n_removed   = r_removed;
        n_err       = r_err;
        n_mod       = r_mod;
        n_ptr       = r_ptr;
        n_found     = r_found;
        n_first     = r_first;
        n_pcnt      = r_pcnt;
        value_we    = 1'b0;
        depth_we    = 1'b0;
        depth_waddr = r_idx;
        scan_new    = scan_cur;

        if (ctrl.exec) begin
            n_err   = 1'b0;
            n_mod   = 1'b0;
            n_ptr   = '0;
            n_found = 1'b0;
            n_first = '0;
            n_pcnt  = '0;
            case (r_op)
                OP_APPEND: begin
                    if (r_loaded >= CNT_W'(ENTRIES)) begin
                        n_err = 1'b1;
                    end else begin
                        value_we = 1'b1;
                        n_present[r_loaded[IDX_W-1:0]] = 1'b1;
                        n_loaded = r_loaded + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (!idx_ok || !depth_ok || !r_present[r_idx]) begin
                        n_err = 1'b1;
                    end else begin
                        depth_we         = 1'b1;
                        n_present[r_idx] = 1'b0;
                        n_removed        = r_removed + CNT_W'(1);
                    end
                end
                OP_REDUCE: begin
                    if (!idx_ok || !depth_ok) begin
                        n_err = 1'b1;
                    end else begin
                        n_mod = 1'b1;
                    end
                end
                OP_RESTORE_DEPTH: begin
                    if (!depth_ok) begin
                        n_err = 1'b1;
                    end else begin
                        n_mod = 1'b1;
                    end
                end
                OP_RESTORE_INDEX: begin
                    if (!idx_ok || !depth_ok || r_present[r_idx] || (r_depth_rd != r_depth)) begin
                        n_err = 1'b1;
                    end else begin
                        n_present[r_idx] = 1'b1;
                        n_removed        = r_removed - CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end

        if (ctrl.scan) begin
            n_ptr = r_ptr + IDX_W'(1);
            if (scan_hit) begin
                // Reduce removes every other present entry; restore depth brings back
                // the entries stamped with this depth. r_depth_rd holds depth_mem[r_ptr].
                if (r_mod && (r_op == OP_REDUCE) && scan_cur && (r_ptr != r_idx)) begin
                    scan_new    = 1'b0;
                    depth_we    = 1'b1;
                    depth_waddr = r_ptr;
                    n_removed   = r_removed + CNT_W'(1);
                end else if (r_mod && (r_op == OP_RESTORE_DEPTH) && !scan_cur &&
                             (r_depth_rd == r_depth)) begin
                    scan_new  = 1'b1;
                    n_removed = r_removed - CNT_W'(1);
                end
                n_present[r_ptr] = scan_new;
                if (scan_new) begin
                    if (!r_found) begin
                        n_found = 1'b1;
                        n_first = r_ptr;
                    end
                    // Only "none", "one" and "more than one" matter.
                    if (r_pcnt != 2'd2) begin
                        n_pcnt = r_pcnt + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '1;
            r_loaded  <= '0;
            r_removed <= '0;
            r_err     <= 1'b0;
            r_mod     <= 1'b0;
            r_ptr     <= '0;
            r_found   <= 1'b0;
            r_first   <= '0;
            r_pcnt    <= '0;
            o_strobe  <= 1'b0;
        end else begin
            r_present <= n_present;
            r_loaded  <= n_loaded;
            r_removed <= n_removed;
            r_err     <= n_err;
            r_mod     <= n_mod;
            r_ptr     <= n_ptr;
            r_found   <= n_found;
            r_first   <= n_first;
            r_pcnt    <= n_pcnt;
            o_strobe  <= ctrl.val_c;
        end
    end

    // Word capture and result payload need no reset.
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_op        <= t_opcode'(i_opcode);
            r_idx       <= i_entry_index;
            r_depth     <= i_search_depth;
            r_new_value <= i_new_value;
        end
        if (ctrl.val_b) begin
            r_single <= r_value_rd;
        end
        if (ctrl.val_c) begin
            o_removed_total       <= r_removed;
            o_entries_loaded      <= r_loaded;
            o_first_present_index <= r_found ? r_first : '0;
            o_any_present         <= r_found;
            o_single_value        <= (r_pcnt == 2'd1) ? r_single : '0;
            o_single_left         <= (r_pcnt == 2'd1);
            o_indexed_value       <= idx_ok ? r_value_rd : '0;
            o_op_error            <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (value_we) begin
            value_mem[r_loaded[IDX_W-1:0]] <= r_new_value;
        end
        r_value_rd <= value_mem[value_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (depth_we) begin
            depth_mem[depth_waddr] <= r_depth;
        end
        r_depth_rd <= depth_mem[depth_raddr];
    end

endmodule

/* bench/trailed_domain_store_core_test.sv */
// Self-checking testbench for trailed_domain_store_core: directed table, then random search traffic.
module trailed_domain_store_core_test
    import tds_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes 6 and 7 are undefined and must be refused by the block.
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    // Returned by the entry picker when no entry of the wanted kind exists.
    localparam int NO_ENTRY = -1;

    localparam int RANDOM_WORDS = 1525;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 80;        // a little over the longest latency of a word
    localparam int CYCLE_LIMIT  = 1_000_000;

    // One command word as the sender presents it.
    typedef struct packed {
        logic [2:0]                opcode;
        logic [IDX_W-1:0]          index;
        logic [DEPTH_W-1:0]        depth;
        logic signed [VALUE_W-1:0] value;
    } t_word;

    // The summary of the domain that every word returns.
    typedef struct packed {
        logic [CNT_W-1:0]          removed_total;
        logic [CNT_W-1:0]          entries_loaded;
        logic [IDX_W-1:0]          first_index;
        logic                      any_present;
        logic signed [VALUE_W-1:0] single_value;
        logic                      single_left;
        logic signed [VALUE_W-1:0] indexed_value;
        logic                      op_error;
    } t_summary;

    // A row of the directed table. Where fixed is set, the summary is typed in by hand
    // and replaces the predicted one; the predictor still tracks the word.
    typedef struct packed {
        t_word    word;
        logic     fixed;
        t_summary summary;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [2:0]                i_opcode = OP_QUERY;
    logic [IDX_W-1:0]          i_entry_index = '0;
    logic [DEPTH_W-1:0]        i_search_depth = '0;
    logic signed [VALUE_W-1:0] i_new_value = '0;
    logic                      o_strobe;
    logic [CNT_W-1:0]          o_removed_total;
    logic [CNT_W-1:0]          o_entries_loaded;
    logic [IDX_W-1:0]          o_first_present_index;
    logic                      o_any_present;
    logic signed [VALUE_W-1:0] o_single_value;
    logic                      o_single_left;
    logic signed [VALUE_W-1:0] o_indexed_value;
    logic                      o_op_error;

    trailed_domain_store_core u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_opcode              (i_opcode),
        .i_entry_index         (i_entry_index),
        .i_search_depth        (i_search_depth),
        .i_new_value           (i_new_value),
        .o_strobe              (o_strobe),
        .o_removed_total       (o_removed_total),
        .o_entries_loaded      (o_entries_loaded),
        .o_first_present_index (o_first_present_index),
        .o_any_present         (o_any_present),
        .o_single_value        (o_single_value),
        .o_single_left         (o_single_left),
        .o_indexed_value       (o_indexed_value),
        .o_op_error            (o_op_error)
    );

    always #10 i_clk = ~i_clk;

    // Our own copy of the domain: values, presence, removal stamps and the two counts.
    logic signed [VALUE_W-1:0] dom_value   [ENTRIES];
    bit                        dom_present [ENTRIES];
    logic [DEPTH_W-1:0]        dom_stamp   [ENTRIES];
    int unsigned               dom_loaded;
    int unsigned               dom_removed;

    t_summary    pending_summaries [$];
    t_row        directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b1;
    int          search_level = 0;      // depth of the current node of the simulated search

    // Applies one accepted word to the domain copy and returns the summary that the
    // block must report for it.
    function automatic t_summary domain_after(t_word w);
        t_summary    s;
        bit          fault;
        bit          index_ok;
        bit          depth_ok;
        bit          seen;
        int unsigned live;
        int unsigned first_idx;
        fault     = 1'b0;
        index_ok  = w.index < dom_loaded;
        depth_ok  = w.depth < MAX_DEPTH;
        seen      = 1'b0;
        live      = 0;
        first_idx = 0;
        case (w.opcode)
            OP_APPEND: begin
                if (dom_loaded >= ENTRIES) begin
                    fault = 1'b1;
                end else begin
                    dom_value[dom_loaded]   = w.value;
                    dom_present[dom_loaded] = 1'b1;
                    dom_stamp[dom_loaded]   = '0;
                    dom_loaded++;
                end
            end
            OP_REMOVE: begin
                if (!index_ok || !depth_ok || !dom_present[w.index]) begin
                    fault = 1'b1;
                end else begin
                    dom_present[w.index] = 1'b0;
                    dom_stamp[w.index]   = w.depth;
                    dom_removed++;
                end
            end
            OP_REDUCE: begin
                // Every other present entry goes, even when the kept index is itself removed.
                if (!index_ok || !depth_ok) begin
                    fault = 1'b1;
                end else begin
                    for (int i = 0; i < dom_loaded; i++) begin
                        if (dom_present[i] && i != w.index) begin
                            dom_present[i] = 1'b0;
                            dom_stamp[i]   = w.depth;
                            dom_removed++;
                        end
                    end
                end
            end
            OP_RESTORE_DEPTH: begin
                // A depth with no removals on it is simply a no-op.
                if (!depth_ok) begin
                    fault = 1'b1;
                end else begin
                    for (int i = 0; i < dom_loaded; i++) begin
                        if (!dom_present[i] && dom_stamp[i] == w.depth) begin
                            dom_present[i] = 1'b1;
                            dom_removed--;
                        end
                    end
                end
            end
            OP_RESTORE_INDEX: begin
                if (!index_ok || !depth_ok || dom_present[w.index] ||
                        dom_stamp[w.index] != w.depth) begin
                    fault = 1'b1;
                end else begin
                    dom_present[w.index] = 1'b1;
                    dom_removed--;
                end
            end
            OP_QUERY: begin
            end
            default: begin
                fault = 1'b1;
            end
        endcase

        for (int i = 0; i < dom_loaded; i++) begin
            if (dom_present[i]) begin
                if (!seen) begin
                    first_idx = i;
                    seen      = 1'b1;
                end
                live++;
            end
        end

        // The indexed read sees the table after the word, so a fresh append reads back.
        s.removed_total  = CNT_W'(dom_removed);
        s.entries_loaded = CNT_W'(dom_loaded);
        s.first_index    = seen ? IDX_W'(first_idx) : '0;
        s.any_present    = seen;
        s.single_value   = (live == 1) ? dom_value[first_idx] : '0;
        s.single_left    = (live == 1);
        s.indexed_value  = (w.index < dom_loaded) ? dom_value[w.index] : '0;
        s.op_error       = fault;
        return s;
    endfunction

    function automatic t_word word_of(logic [2:0] op, int idx, int depth,
                                      logic [VALUE_W-1:0] value);
        t_word w;
        w.opcode = op;
        w.index  = IDX_W'(idx);
        w.depth  = DEPTH_W'(depth);
        w.value  = value;
        return w;
    endfunction

    // Files one row at the end of the directed table.
    function automatic void add_row(t_word w, logic fixed, t_summary s);
        t_row row;
        row.word    = w;
        row.fixed   = fixed;
        row.summary = s;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Queues the summary that the next strobed result must carry.
    function automatic void expect_summary(t_summary s);
        pending_summaries.insert(pending_summaries.size(), s);
    endfunction

    // Picks a loaded entry at random among those that are present (or removed).
    function automatic int pick_entry(bit want_present);
        int hits;
        int k;
        hits = 0;
        for (int i = 0; i < dom_loaded; i++) begin
            if (dom_present[i] == want_present) hits++;
        end
        if (hits == 0) return NO_ENTRY;
        k = $urandom_range(0, hits - 1);
        for (int i = 0; i < dom_loaded; i++) begin
            if (dom_present[i] == want_present) begin
                if (k == 0) return i;
                k--;
            end
        end
        return NO_ENTRY;
    endfunction

    // Builds the next random word. Most words follow a backtracking search: removals and
    // reductions stamp the current level and descend, restores by depth climb back up, and
    // single restores name a removed entry with its own stamp. The rest is plain noise.
    function automatic t_word next_search_word();
        t_word w;
        int    roll;
        int    pick;
        roll = $urandom_range(0, 99);
        w    = word_of(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        if (roll < 8) begin
            // Appends keep coming after the table is full so the overflow is hit too.
            w.opcode = OP_APPEND;
        end else if (roll < 30) begin
            pick = pick_entry(1'b1);
            if (pick != NO_ENTRY) begin
                w.opcode = OP_REMOVE;
                w.index  = IDX_W'(pick);
                w.depth  = DEPTH_W'(search_level);
                if (search_level < MAX_DEPTH - 1) search_level++;
            end else begin
                w.opcode = OP_RESTORE_DEPTH;
            end
        end else if (roll < 38) begin
            w.opcode = OP_REDUCE;
            if (dom_loaded != 0) w.index = IDX_W'($urandom_range(0, dom_loaded - 1));
            w.depth = DEPTH_W'(search_level);
            if (search_level < MAX_DEPTH - 1) search_level++;
        end else if (roll < 68) begin
            w.opcode = OP_RESTORE_DEPTH;
            if (search_level > 0) begin
                search_level--;
                w.depth = DEPTH_W'(search_level);
            end
        end else if (roll < 78) begin
            w.opcode = OP_RESTORE_INDEX;
            pick     = pick_entry(1'b0);
            if (pick != NO_ENTRY) begin
                w.index = IDX_W'(pick);
                w.depth = dom_stamp[pick];
            end
        end else if (roll >= 85) begin
            w.opcode = 3'($urandom_range(0, 7));
        end
        return w;
    endfunction

    // Presents one word, waits for the block to take it and records what must come back.
    // Called at a rising edge and returns at the edge that accepts the word.
    task automatic send_word(t_word w, logic fixed, t_summary fixed_summary);
        t_summary predicted;
        if (gaps_on && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= w.opcode;
        i_entry_index  <= w.index;
        i_search_depth <= w.depth;
        i_new_value    <= w.value;
        // busy only moves on a rising edge, so mid-cycle tells whether the next edge accepts.
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        predicted = domain_after(w);
        expect_summary(fixed ? fixed_summary : predicted);
    endtask

    // Holds the sender off until every outstanding word has reported back.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_summaries.size() != 0);
    endtask

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // The result strobe is high for one cycle; mid-cycle sampling sees each result exactly once.
    always @(negedge i_clk) begin
        t_summary want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_summaries.size() == 0) begin
                $display("%0t: result strobed with no word outstanding, expected none, actual %0h",
                         $time, o_removed_total);
                mismatch_count++;
            end else begin
                want = pending_summaries.pop_front();
                check_field("removed_total", VALUE_W'(want.removed_total),
                            VALUE_W'(o_removed_total));
                check_field("entries_loaded", VALUE_W'(want.entries_loaded),
                            VALUE_W'(o_entries_loaded));
                check_field("first_present_index", VALUE_W'(want.first_index),
                            VALUE_W'(o_first_present_index));
                check_field("any_present", VALUE_W'(want.any_present),
                            VALUE_W'(o_any_present));
                check_field("single_value", want.single_value, o_single_value);
                check_field("single_left", VALUE_W'(want.single_left),
                            VALUE_W'(o_single_left));
                check_field("indexed_value", want.indexed_value, o_indexed_value);
                check_field("op_error", VALUE_W'(want.op_error), VALUE_W'(o_op_error));
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL trailed_domain_store_core");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            dom_value[i]   = '0;
            dom_present[i] = 1'b1;
            dom_stamp[i]   = '0;
        end
        dom_loaded  = 0;
        dom_removed = 0;

        // Directed table. Hand-typed summaries only where they are obvious: the empty
        // domain, the first append of the most negative value and plain refusals.
        add_row(word_of(OP_QUERY, 0, 0, 32'h0), 1'b1,
            '{7'd0, 7'd0, 6'd0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0});
        // Removing from an empty domain is refused.
        add_row(word_of(OP_REMOVE, 0, 0, 32'h0), 1'b1,
            '{7'd0, 7'd0, 6'd0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1});
        add_row(word_of(OP_APPEND, 0, 0, 32'h8000_0000), 1'b1,
            '{7'd0, 7'd1, 6'd0, 1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0});
        add_row(word_of(OP_APPEND, 1, 63, 32'h7FFF_FFFF), 1'b0, '0);
        add_row(word_of(OP_APPEND, 2, 0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(word_of(OP_APPEND, 3, 0, 32'h0), 1'b0, '0);
        // Index beyond the loaded entries is refused and reads back as zero.
        add_row(word_of(OP_REMOVE, 63, 63, 32'hFFFF_FFFF), 1'b1,
            '{7'd0, 7'd4, 6'd0, 1'b1, 32'h0, 1'b0, 32'h0, 1'b1});
        add_row(word_of(OP_REMOVE, 1, 63, 32'h0), 1'b0, '0);
        // A second removal of the same entry, a restore at the wrong depth and a
        // restore of a present entry are all refused.
        add_row(word_of(OP_REMOVE, 1, 5, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_INDEX, 1, 5, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_INDEX, 0, 0, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_INDEX, 1, 63, 32'h0), 1'b0, '0);
        add_row(word_of(OP_REDUCE, 2, 7, 32'h0), 1'b0, '0);
        // Restoring a depth nobody was removed at changes nothing.
        add_row(word_of(OP_RESTORE_DEPTH, 0, 9, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_DEPTH, 2, 7, 32'h0), 1'b0, '0);
        // Reducing to an entry that is already removed leaves the domain empty.
        add_row(word_of(OP_REMOVE, 2, 3, 32'h0), 1'b0, '0);
        add_row(word_of(OP_REDUCE, 2, 4, 32'h0), 1'b0, '0);
        add_row(word_of(OP_QUERY, 3, 0, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_DEPTH, 0, 4, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_DEPTH, 0, 3, 32'h0), 1'b0, '0);
        // Undefined opcodes are refused.
        add_row(word_of(OP_UNDEF_LO, 63, 0, 32'h0), 1'b1,
            '{7'd0, 7'd4, 6'd0, 1'b1, 32'h0, 1'b0, 32'h0, 1'b1});
        add_row(word_of(OP_UNDEF_HI, 2, 63, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(word_of(OP_REDUCE, 63, 0, 32'h0), 1'b0, '0);
        add_row(word_of(OP_RESTORE_INDEX, 60, 1, 32'h0), 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].word, directed_rows[r].fixed, directed_rows[r].summary);
        end
        wait_for_results();

        // Random search traffic. The table fills over the first several hundred words, so
        // short scans come first and full 64-entry scans dominate later on.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps_on = !(n >= 500 && n < 800);
            if (n == 1000) wait_for_results();
            send_word(next_search_word(), 1'b0, '0);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_summaries.size() == 0) begin
            $display("PASS trailed_domain_store_core");
        end else begin
            $display("FAIL trailed_domain_store_core");
        end
        $finish;
    end

endmodule

/* trailed_domain_store_core.f */
rtl/tds_pkg.sv
rtl/tds_ctrl.sv
rtl/trailed_domain_store_core.sv
bench/trailed_domain_store_core_test.sv
